### rtl/core/btc_pkg.sv
`timescale 1ns / 1ps

package btc_pkg;

  // Width of the press and since-tap counters; they saturate at all ones.
  localparam int COUNT_WIDTH = 16;

  // Width of the configuration registers.
  localparam int REG_WIDTH = 16;

  // Common width for comparing a counter with a register.
  localparam int CMP_WIDTH = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

  // Width of the configuration register index.
  localparam int CFG_INDEX_WIDTH = 8;

  // Packed bus widths, padded to whole bytes.
  localparam int IN_DATA_WIDTH  = 8;
  localparam int OUT_DATA_WIDTH = 8;

  // Reset values of the configuration registers.
  localparam logic [REG_WIDTH-1:0] HOLD_TICKS_RST    = 16'd300;
  localparam logic [REG_WIDTH-1:0] TIMEOUT_TICKS_RST = 16'd60;

  // Taps needed to start the access point.
  localparam logic [1:0] TAPS_FOR_AP = 2'd3;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_HOLD_TICKS    = 8'd0,
    REG_TIMEOUT_TICKS = 8'd1
  } reg_index_t;

  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_TAP           = 3'd1,
    EV_WIFI_AP       = 3'd2,
    EV_FORCE_RESTART = 3'd3,
    EV_FACTORY_RESET = 3'd4,
    EV_REQ_STOP      = 3'd5,
    EV_REQ_RUN       = 3'd6,
    EV_TAP_TIMEOUT   = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_BOOT  = 3'b010,
    MODE_POWER = 3'b100
  } mode_t;

  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (v == {COUNT_WIDTH{1'b1}}) ? v : v + count_t'(1);
    return r;
  endfunction

endpackage

### rtl/core/button_tap_hold_classifier.sv
`timescale 1ns / 1ps

// Result: the result of an accepted input beat is registered and shows on m_tdata in the next cycle.
// Throughput: one input beat per clock while m_tready is high; s_tready = output register
//   empty or being drained, so the single result register sets the rate.
// Reset (rst, synchronous, active high): no button held, counters and tap count zero,
//   hold_ticks = 300, timeout_ticks = 60, no result pending.
module button_tap_hold_classifier (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [0] boot_pressed, [1] power_pressed, [2] device_active, [7:3] zero
  input  logic [btc_pkg::IN_DATA_WIDTH-1:0]    s_tdata,
  // Result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [2:0] event_res, [7:3] zero
  output logic [btc_pkg::OUT_DATA_WIDTH-1:0]   m_tdata,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [btc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [btc_pkg::REG_WIDTH-1:0]        cfg_data
);

  import btc_pkg::*;

  // Configuration registers
  logic [REG_WIDTH-1:0] hold_ticks;
  logic [REG_WIDTH-1:0] timeout_ticks;

  // Classifier state
  mode_t      held_mode, held_mode_next;
  count_t     press_count, press_count_next;
  count_t     since_tap_count, since_tap_count_next;
  logic [1:0] tap_total, tap_total_next;

  // Result register
  logic   out_valid;
  event_t out_event, event_next;

  logic boot_pressed, power_pressed, device_active;
  logic in_beat;
  logic long_hold;
  logic timed_out;
  logic [1:0] tap_inc;
  count_t since_inc, press_inc;
  event_t timeout_event;

  assign boot_pressed  = s_tdata[0];
  assign power_pressed = s_tdata[1];
  assign device_active = s_tdata[2];

  // Accept whenever the result register is free or drains this cycle.
  assign s_tready = !out_valid || m_tready;
  assign in_beat  = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_WIDTH-3){1'b0}}, out_event};

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks    <= HOLD_TICKS_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HOLD_TICKS:    hold_ticks    <= cfg_data;
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign since_inc = sat_inc(since_tap_count);
  assign press_inc = sat_inc(press_count);
  assign tap_inc   = tap_total + 2'd1;

  // A release counts as long once the held count reaches hold_ticks.
  assign long_hold = CMP_WIDTH'(press_count) >= CMP_WIDTH'(hold_ticks);

  // Pending taps resolve once the incremented gap passes timeout_ticks.
  assign timed_out = (tap_total != 2'd0) &&
                     (CMP_WIDTH'(since_inc) > CMP_WIDTH'(timeout_ticks));

  always_comb begin
    if (tap_total == 2'd1) begin
      timeout_event = device_active ? EV_REQ_STOP : EV_REQ_RUN;
    end else begin
      timeout_event = EV_TAP_TIMEOUT;
    end
  end

  always_comb begin
    held_mode_next       = held_mode;
    press_count_next     = press_count;
    since_tap_count_next = since_inc;
    tap_total_next       = tap_total;
    event_next           = EV_NONE;

    case (held_mode)
      MODE_BOOT: begin
        if (boot_pressed) begin
          press_count_next = press_inc;
        end else begin
          held_mode_next = MODE_IDLE;
          if (long_hold) begin
            tap_total_next = 2'd0;
            event_next     = EV_FACTORY_RESET;
          end else if (timed_out) begin
            // short boot press: only resolve taps that have expired
            tap_total_next = 2'd0;
            event_next     = timeout_event;
          end
        end
      end
      MODE_POWER: begin
        if (power_pressed) begin
          press_count_next = press_inc;
        end else begin
          held_mode_next = MODE_IDLE;
          if (long_hold) begin
            tap_total_next = 2'd0;
            event_next     = EV_FORCE_RESTART;
          end else begin
            // short power press is a tap; restart the gap counter
            since_tap_count_next = '0;
            if (tap_inc >= TAPS_FOR_AP) begin
              tap_total_next = 2'd0;
              event_next     = EV_WIFI_AP;
            end else begin
              tap_total_next = tap_inc;
              event_next     = EV_TAP;
            end
          end
        end
      end
      default: begin
        // idle: boot wins when both buttons are down
        held_mode_next = MODE_IDLE;
        if (boot_pressed) begin
          held_mode_next   = MODE_BOOT;
          press_count_next = count_t'(1);
        end else if (power_pressed) begin
          held_mode_next   = MODE_POWER;
          press_count_next = count_t'(1);
        end else if (timed_out) begin
          tap_total_next = 2'd0;
          event_next     = timeout_event;
        end
      end
    endcase
  end

  // Advance the classifier state on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_mode       <= MODE_IDLE;
      press_count     <= '0;
      since_tap_count <= '0;
      tap_total       <= 2'd0;
    end else if (in_beat) begin
      held_mode       <= held_mode_next;
      press_count     <= press_count_next;
      since_tap_count <= since_tap_count_next;
      tap_total       <= tap_total_next;
    end
  end

  // Result register: load on an input beat, clear valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_event <= event_next;
    end
  end

endmodule
